// ===== hw/rtl/pac_pkg.sv =====
// Package of shared widths, controller/datapath structs and helpers for the polygon centroid.
package pac_pkg;

  // Coordinate and accumulator widths
  localparam int COORD_BITS     = 16;
  localparam int SUM_BITS       = COORD_BITS + 1;
  localparam int PROD_BITS      = 2 * COORD_BITS;
  localparam int CROSS_BITS     = PROD_BITS + 1;
  localparam int AREA_TERM_BITS = 2 * SUM_BITS;
  localparam int CSUM_TERM_BITS = SUM_BITS + CROSS_BITS;
  localparam int AREA_BITS      = 43;
  localparam int CSUM_BITS      = 58;
  localparam int OUT_AREA_BITS  = 42;

  // Quotient keeps one bit above the coordinate range to flag saturation
  localparam int QUO_BITS = COORD_BITS + 1;

  // Default vertex limit per polygon
  localparam int MAX_VERTICES_DEF = 1024;

  // Stream word layout
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 2;

  // Commands from controller to datapath
  typedef struct packed {
    logic take_first;
    logic add_edge;
    logic close_edge;
    logic prep;
    logic start;
    logic load_out;
    logic too_many;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_done;
  } status_t;

  // Turn a quotient magnitude into a signed, saturated coordinate
  function automatic logic [COORD_BITS-1:0] centre_fix(
    input logic [QUO_BITS-1:0] q,
    input logic                neg,
    input logic                zero
  );
    logic [QUO_BITS-1:0]   lim;
    logic [COORD_BITS-1:0] res;
    lim = QUO_BITS'(1) << (COORD_BITS - 1);
    if (zero) begin
      res = '0;
    end else if (neg) begin
      if (q >= lim) begin
        res = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
        res = COORD_BITS'(QUO_BITS'(0) - q);
      end
    end else begin
      if (q > lim - QUO_BITS'(1)) begin
        res = {1'b0, {(COORD_BITS-1){1'b1}}};
      end else begin
        res = q[COORD_BITS-1:0];
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/pac_div.sv =====
// Restoring divider: unsigned numerator over three times an unsigned area, one bit a cycle.
module pac_div #(
  parameter int NUM_W = pac_pkg::CSUM_BITS,
  parameter int DEN_W = pac_pkg::AREA_BITS,
  parameter int Q_W   = pac_pkg::QUO_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o,
  output logic             done_o
);

  localparam int TRI_W = DEN_W + 2;
  localparam int DS_W  = TRI_W + Q_W - 1;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DS_W-1:0]  ds_q;
  logic [NUM_W-1:0] rem_q;
  logic [Q_W-1:0]   quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [TRI_W-1:0] tri_den;
  logic             ge;

  // Triple the divisor with one shift and add
  assign tri_den = TRI_W'(den_i) + (TRI_W'(den_i) << 1);
  assign ge      = DS_W'(rem_q) >= ds_q;

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(Q_W);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      busy_q <= cnt_q != CNT_W'(1);
    end
  end

  // Shift, compare and subtract; the top quotient bit marks an oversize result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ds_q  <= DS_W'(tri_den) << (Q_W - 1);
      rem_q <= num_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - NUM_W'(ds_q);
      end
      quo_q <= {quo_q[Q_W-2:0], ge};
      ds_q  <= ds_q >> 1;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = !busy_q;

endmodule

// ===== hw/rtl/pac_dpath.sv =====
// Datapath: edge products, shoelace accumulators, centroid dividers and result word.
module pac_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pac_pkg::cmd_t                         cmd_i,
  input  logic signed [pac_pkg::COORD_BITS-1:0] x_i,
  input  logic signed [pac_pkg::COORD_BITS-1:0] y_i,
  input  logic signed [pac_pkg::COORD_BITS-1:0] z_i,
  output pac_pkg::status_t                      status_o,
  output logic [pac_pkg::COORD_BITS-1:0]        cx_o,
  output logic [pac_pkg::COORD_BITS-1:0]        cy_o,
  output logic [pac_pkg::COORD_BITS-1:0]        cz_o,
  output logic [pac_pkg::OUT_AREA_BITS-1:0]     area_o,
  output logic                                  degen_o,
  output logic                                  over_o
);

  localparam int CW  = pac_pkg::COORD_BITS;
  localparam int SW  = pac_pkg::SUM_BITS;
  localparam int PW  = pac_pkg::PROD_BITS;
  localparam int XW  = pac_pkg::CROSS_BITS;
  localparam int ATW = pac_pkg::AREA_TERM_BITS;
  localparam int CTW = pac_pkg::CSUM_TERM_BITS;
  localparam int AW  = pac_pkg::AREA_BITS;
  localparam int CSW = pac_pkg::CSUM_BITS;
  localparam int OAW = pac_pkg::OUT_AREA_BITS;
  localparam int QW  = pac_pkg::QUO_BITS;

  // Vertex store
  logic signed [CW-1:0] first_x_q, first_y_q, first_z_q, prev_x_q, prev_z_q;

  // Edge operands
  logic signed [CW-1:0] xj, zj;
  logic                 edge_v;

  // Pipeline registers
  logic                  v1_q, v2_q;
  logic signed [PW-1:0]  pa_q, pb_q;
  logic signed [SW-1:0]  sx_q, sz_q;
  logic signed [ATW-1:0] ma_q, ma2_q;
  logic signed [SW-1:0]  sx_d, sz_d, dx_d;
  logic signed [ATW-1:0] ma_d;
  logic signed [XW-1:0]  xprod;
  logic signed [CTW-1:0] mx_d, mz_d, mx_q, mz_q;

  // Accumulators
  logic signed [AW-1:0]  area_sum_q;
  logic signed [CSW-1:0] cx_sum_q, cz_sum_q;

  // Divider operands
  logic [CSW-1:0] nx_q, nz_q;
  logic [AW-1:0]  den_q;
  logic           a_neg_q, nx_neg_q, nz_neg_q, nx_zero_q, nz_zero_q, degen_q;
  logic [OAW-1:0] ta_q;
  logic [QW-1:0]  qx, qz;
  logic           dx_done, dz_done;

  // Store first and previous vertex
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      first_z_q <= '0;
      prev_x_q  <= '0;
      prev_z_q  <= '0;
    end else if (cmd_i.take_first) begin
      first_x_q <= x_i;
      first_y_q <= y_i;
      first_z_q <= z_i;
      prev_x_q  <= x_i;
      prev_z_q  <= z_i;
    end else if (cmd_i.add_edge) begin
      prev_x_q <= x_i;
      prev_z_q <= z_i;
    end
  end

  // Pick the far end of the edge: new vertex or back to the first
  assign xj     = cmd_i.close_edge ? first_x_q : x_i;
  assign zj     = cmd_i.close_edge ? first_z_q : z_i;
  assign edge_v = cmd_i.add_edge || cmd_i.close_edge;

  assign sx_d = SW'(prev_x_q) + SW'(xj);
  assign sz_d = SW'(prev_z_q) + SW'(zj);
  assign dx_d = SW'(xj) - SW'(prev_x_q);
  assign ma_d = sz_d * dx_d;

  // Stage one: cross products and area term
  always_ff @(posedge clk_i) begin
    pa_q <= prev_x_q * zj;
    pb_q <= xj * prev_z_q;
    sx_q <= sx_d;
    sz_q <= sz_d;
    ma_q <= ma_d;
  end

  assign xprod = XW'(pa_q) - XW'(pb_q);
  assign mx_d  = sx_q * xprod;
  assign mz_d  = sz_q * xprod;

  // Stage two: centroid terms
  always_ff @(posedge clk_i) begin
    mx_q  <= mx_d;
    mz_q  <= mz_d;
    ma2_q <= ma_q;
  end

  // Advance the edge valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= edge_v;
      v2_q <= v1_q;
    end
  end

  // Stage three: wrapping accumulation, cleared once the sums are taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_sum_q <= '0;
      cx_sum_q   <= '0;
      cz_sum_q   <= '0;
    end else if (cmd_i.prep) begin
      area_sum_q <= '0;
      cx_sum_q   <= '0;
      cz_sum_q   <= '0;
    end else if (v2_q) begin
      area_sum_q <= area_sum_q + AW'(ma2_q);
      cx_sum_q   <= cx_sum_q + CSW'(mx_q);
      cz_sum_q   <= cz_sum_q + CSW'(mz_q);
    end
  end

  // Take magnitudes and signs for division, saturate the area
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      a_neg_q   <= area_sum_q[AW-1];
      nx_neg_q  <= cx_sum_q[CSW-1];
      nz_neg_q  <= cz_sum_q[CSW-1];
      nx_zero_q <= cx_sum_q == '0;
      nz_zero_q <= cz_sum_q == '0;
      degen_q   <= area_sum_q == '0;
      den_q     <= area_sum_q[AW-1] ? AW'(-area_sum_q) : AW'(area_sum_q);
      nx_q      <= cx_sum_q[CSW-1] ? CSW'(-cx_sum_q) : CSW'(cx_sum_q);
      nz_q      <= cz_sum_q[CSW-1] ? CSW'(-cz_sum_q) : CSW'(cz_sum_q);
      if (area_sum_q[AW-1] != area_sum_q[OAW-1]) begin
        ta_q <= area_sum_q[AW-1] ? {1'b1, {(OAW-1){1'b0}}} : {1'b0, {(OAW-1){1'b1}}};
      end else begin
        ta_q <= area_sum_q[OAW-1:0];
      end
    end
  end

  pac_div #(
    .NUM_W(CSW),
    .DEN_W(AW),
    .Q_W  (QW)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .num_i  (nx_q),
    .den_i  (den_q),
    .quo_o  (qx),
    .done_o (dx_done)
  );

  pac_div #(
    .NUM_W(CSW),
    .DEN_W(AW),
    .Q_W  (QW)
  ) u_div_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .num_i  (nz_q),
    .den_i  (den_q),
    .quo_o  (qz),
    .done_o (dz_done)
  );

  assign status_o.div_done = dx_done && dz_done;

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      cx_o    <= pac_pkg::centre_fix(qx, nx_neg_q == a_neg_q, degen_q || nx_zero_q);
      cz_o    <= pac_pkg::centre_fix(qz, nz_neg_q == a_neg_q, degen_q || nz_zero_q);
      cy_o    <= first_y_q;
      area_o  <= ta_q;
      degen_o <= degen_q;
      over_o  <= cmd_i.too_many;
    end
  end

endmodule

// ===== hw/rtl/pac_ctrl.sv =====
// Controller: vertex counting, polygon close, drain, divide and result handshake.
module pac_ctrl #(
  parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pac_pkg::status_t status_i,
  output pac_pkg::cmd_t    cmd_o
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 2);

  localparam logic [2:0] S_ACCUM = 3'd0;
  localparam logic [2:0] S_CLOSE = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drain_q, drain_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             load;

  assign accept = in_valid_i && (state_q == S_ACCUM);
  assign load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    unique case (state_q)
      S_ACCUM: begin
        if (accept && in_last_i) state_d = S_CLOSE;
      end
      S_CLOSE: begin
        state_d = S_DRAIN;
        drain_d = 1'b0;
      end
      S_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) state_d = S_PREP;
      end
      S_PREP:  state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV: begin
        if (status_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (load) state_d = S_ACCUM;
      end
      default: state_d = S_ACCUM;
    endcase
  end

  // Count vertices of the polygon, saturating one above the limit
  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = '0;
    end else if (accept) begin
      if (cnt_q == '0) begin
        cnt_d = CNT_W'(1);
      end else if (cnt_q < CNT_W'(MAX_VERTICES)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        cnt_d = CNT_W'(MAX_VERTICES + 1);
      end
    end
  end

  // Hold the result word until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACCUM;
      cnt_q       <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath commands
  assign cmd_o.take_first = accept && (cnt_q == '0);
  assign cmd_o.add_edge   = accept && (cnt_q != '0) && (cnt_q < CNT_W'(MAX_VERTICES));
  assign cmd_o.close_edge = state_q == S_CLOSE;
  assign cmd_o.prep       = state_q == S_PREP;
  assign cmd_o.start      = state_q == S_START;
  assign cmd_o.load_out   = load;
  assign cmd_o.too_many   = cnt_q > CNT_W'(MAX_VERTICES);

  assign in_ready_o  = state_q == S_ACCUM;
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/polygon_area_centroid.sv =====
// Top level: shoelace area and centroid of a streamed polygon in the x-z plane.
//
// Vertices enter on the slave stream, one word each, the last vertex of a
// polygon marked by s_axis_tlast. Words are taken one per cycle while the
// polygon is open. After the last vertex the block adds the closing edge,
// drains its three-stage multiply-accumulate pipe and runs two 17-step
// restoring dividers in parallel (one bit per cycle) for the centre x and z.
// One result word then leaves on the master stream for each polygon.
// The input stays stalled from the last vertex until the result has been
// loaded into the output register, so a stalled receiver holds the next
// polygon back once a result waits there and another is ready.
// Vertices beyond MAX_VERTICES are taken but not summed; too_many is raised.
// A zero area raises degenerate and gives a zero centre.
// Reset clears the vertex store, sums and count and empties the output.
module polygon_area_centroid #(
  parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // vertex_x [15:0], vertex_y [31:16], vertex_z [47:32]
  input  logic [pac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // center_x [15:0], center_y [31:16], center_z [47:32], twice_area [89:48], zero [95:90]
  output logic [pac_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // degenerate [0], too_many [1]
  output logic [pac_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  localparam int CW  = pac_pkg::COORD_BITS;
  localparam int OAW = pac_pkg::OUT_AREA_BITS;

  pac_pkg::cmd_t    cmd;
  pac_pkg::status_t status;
  logic [CW-1:0]    cx, cy, cz;
  logic [OAW-1:0]   ta;
  logic             degen, over;

  pac_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pac_dpath u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .x_i     (s_axis_tdata[CW-1:0]),
    .y_i     (s_axis_tdata[2*CW-1:CW]),
    .z_i     (s_axis_tdata[3*CW-1:2*CW]),
    .status_o(status),
    .cx_o    (cx),
    .cy_o    (cy),
    .cz_o    (cz),
    .area_o  (ta),
    .degen_o (degen),
    .over_o  (over)
  );

  // Pack the result word
  assign m_axis_tdata = {{(pac_pkg::OUT_TDATA_W - 3*CW - OAW){1'b0}}, ta, cz, cy, cx};
  assign m_axis_tuser = {over, degen};

  // A zero area always comes with a zero centre
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (cx == '0 && cz == '0))
    else $error("degenerate result with non-zero centre");

  // The degenerate flag tracks a zero area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] == (ta == '0)))
    else $error("degenerate flag disagrees with area");

  // Taking the last vertex of a polygon drops the input ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken while a polygon closes");

endmodule
